### src/rc4_pkg.sv
package rc4_pkg;

   localparam int MAX_KEY_BYTES_DEFAULT = 16;
   localparam int SBOX_DEPTH            = 256;
   localparam int BYTE_WIDTH            = 8;
   localparam int KEY_LENGTH_WIDTH      = 5;

   localparam logic [KEY_LENGTH_WIDTH-1:0] KEY_LENGTH_RESET = 5'd13;

   // Action codes of a request word.
   localparam logic [1:0] ACT_LOAD     = 2'd0;
   localparam logic [1:0] ACT_SCHEDULE = 2'd1;
   localparam logic [1:0] ACT_NEXT     = 2'd2;

   typedef struct packed {
      logic [1:0]            action;
      logic [3:0]            key_index;
      logic [BYTE_WIDTH-1:0] key_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] keystream_byte;
      logic                  not_scheduled;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic key_we;
      logic init_start;
      logic init_wr;
      logic ks_rda;
      logic ks_rdb;
      logic ks_wra;
      logic ks_wrb;
      logic gen_rdi;
      logic gen_rdj;
      logic gen_wri;
      logic gen_wrj;
      logic gen_fin;
      logic flag_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic a_last;
      logic scheduled;
   } sts_type;

endpackage

### src/rc4_ram.sv
module rc4_ram #(
   parameter int WIDTH = rc4_pkg::BYTE_WIDTH,
   parameter int DEPTH = rc4_pkg::SBOX_DEPTH
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/rc4_controller.sv
module rc4_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        action,
   input  rc4_pkg::sts_type  sts,
   output logic              busy,
   output rc4_pkg::cmd_type  cmd
);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_INIT   = 11'b000_0000_0010,
      ST_KS_RDA = 11'b000_0000_0100,
      ST_KS_RDB = 11'b000_0000_1000,
      ST_KS_WRA = 11'b000_0001_0000,
      ST_KS_WRB = 11'b000_0010_0000,
      ST_G_RDI  = 11'b000_0100_0000,
      ST_G_RDJ  = 11'b000_1000_0000,
      ST_G_WRI  = 11'b001_0000_0000,
      ST_G_WRJ  = 11'b010_0000_0000,
      ST_G_FIN  = 11'b100_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (action)
                  rc4_pkg::ACT_LOAD: begin
                     cmd.key_we = 1'b1;
                  end
                  rc4_pkg::ACT_SCHEDULE: begin
                     cmd.init_start = 1'b1;
                     state_in       = ST_INIT;
                  end
                  rc4_pkg::ACT_NEXT: begin
                     if (sts.scheduled) begin
                        state_in = ST_G_RDI;
                     end else begin
                        cmd.flag_rsp = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (sts.a_last) begin
               state_in = ST_KS_RDA;
            end
         end
         ST_KS_RDA: begin
            cmd.ks_rda = 1'b1;
            state_in   = ST_KS_RDB;
         end
         ST_KS_RDB: begin
            cmd.ks_rdb = 1'b1;
            state_in   = ST_KS_WRA;
         end
         ST_KS_WRA: begin
            cmd.ks_wra = 1'b1;
            state_in   = ST_KS_WRB;
         end
         ST_KS_WRB: begin
            cmd.ks_wrb = 1'b1;
            state_in   = sts.a_last ? ST_IDLE : ST_KS_RDA;
         end
         ST_G_RDI: begin
            cmd.gen_rdi = 1'b1;
            state_in    = ST_G_RDJ;
         end
         ST_G_RDJ: begin
            cmd.gen_rdj = 1'b1;
            state_in    = ST_G_WRI;
         end
         ST_G_WRI: begin
            cmd.gen_wri = 1'b1;
            state_in    = ST_G_WRJ;
         end
         ST_G_WRJ: begin
            cmd.gen_wrj = 1'b1;
            state_in    = ST_G_FIN;
         end
         ST_G_FIN: begin
            cmd.gen_fin = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### src/rc4_datapath.sv
module rc4_datapath #(
   parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rc4_pkg::cmd_type                      cmd,
   input  rc4_pkg::req_type                      req,
   input  logic                                  csr_we,
   input  logic [rc4_pkg::KEY_LENGTH_WIDTH-1:0]  csr_wdata,
   output logic                                  rsp_strobe,
   output rc4_pkg::rsp_type                      rsp_word,
   output rc4_pkg::sts_type                      sts
);

   localparam int BW = rc4_pkg::BYTE_WIDTH;
   localparam int SW = $clog2(rc4_pkg::SBOX_DEPTH);
   localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int CW = $clog2(MAX_KEY_BYTES + 1);
   localparam int NW = (CW > rc4_pkg::KEY_LENGTH_WIDTH) ? CW : rc4_pkg::KEY_LENGTH_WIDTH;
   localparam logic [NW-1:0] MAX_N = NW'(MAX_KEY_BYTES);

   logic [rc4_pkg::KEY_LENGTH_WIDTH-1:0] klen_ff, klen_in;
   logic            sched_ff, sched_in;
   logic [BW-1:0]   i_ff, i_in;
   logic [BW-1:0]   j_ff, j_in;
   logic [SW-1:0]   a_ff, a_in;
   logic [BW-1:0]   b_ff, b_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [BW-1:0]   hold_ff, hold_in;
   logic [BW-1:0]   t_ff, t_in;
   logic            byp_ff, byp_in;
   logic            valid_ff, valid_in;
   rc4_pkg::rsp_type rsp_ff, rsp_in;

   logic            sb_we;
   logic [SW-1:0]   sb_waddr;
   logic [BW-1:0]   sb_wdata;
   logic [SW-1:0]   sb_raddr;
   logic [BW-1:0]   sb_rdata;
   logic            key_we;
   logic [BW-1:0]   key_rdata;

   logic [NW-1:0]   klen_w;
   logic [NW-1:0]   eff_n;
   logic            k_last;
   logic [BW-1:0]   b_new;
   logic [BW-1:0]   j_new;
   logic [BW-1:0]   i_next;

   // Key length of zero uses one byte; lengths above the store saturate.
   assign klen_w = NW'(klen_ff);
   always_comb begin
      if (klen_ff == '0) begin
         eff_n = NW'(1);
      end else if (klen_w > MAX_N) begin
         eff_n = MAX_N;
      end else begin
         eff_n = klen_w;
      end
   end

   assign k_last = ((NW'(k_ff) + NW'(1)) >= eff_n);
   assign b_new  = b_ff + sb_rdata + key_rdata;
   assign j_new  = j_ff + sb_rdata;
   assign i_next = i_ff + BW'(1);
   assign key_we = cmd.key_we && (NW'(req.key_index) < MAX_N);

   always_comb begin
      if (cmd.ks_rdb) begin
         sb_raddr = b_new;
      end else if (cmd.gen_rdi) begin
         sb_raddr = i_next;
      end else if (cmd.gen_rdj) begin
         sb_raddr = j_new;
      end else if (cmd.gen_wrj) begin
         sb_raddr = t_ff;
      end else if (cmd.ks_rda) begin
         sb_raddr = a_ff;
      end else begin
         sb_raddr = a_ff;
      end
   end

   always_comb begin
      sb_we    = 1'b0;
      sb_waddr = a_ff;
      sb_wdata = sb_rdata;
      if (cmd.init_wr) begin
         sb_we    = 1'b1;
         sb_wdata = a_ff;
      end else if (cmd.ks_wra) begin
         sb_we = 1'b1;
      end else if (cmd.ks_wrb) begin
         sb_we    = 1'b1;
         sb_waddr = b_ff;
         sb_wdata = hold_ff;
      end else if (cmd.gen_wri) begin
         sb_we    = 1'b1;
         sb_waddr = i_ff;
      end else if (cmd.gen_wrj) begin
         sb_we    = 1'b1;
         sb_waddr = j_ff;
         sb_wdata = hold_ff;
      end
   end

   always_comb begin
      klen_in  = csr_we ? csr_wdata : klen_ff;
      sched_in = sched_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      hold_in  = hold_ff;
      t_in     = t_ff;
      byp_in   = byp_ff;
      valid_in = cmd.gen_fin || cmd.flag_rsp;
      rsp_in   = rsp_ff;
      if (cmd.init_start) begin
         a_in = '0;
         b_in = '0;
         k_in = '0;
      end
      if (cmd.init_wr) begin
         a_in = a_ff + SW'(1);
      end
      if (cmd.ks_rdb) begin
         b_in    = b_new;
         hold_in = sb_rdata;
      end
      if (cmd.ks_wrb) begin
         a_in = a_ff + SW'(1);
         k_in = k_last ? '0 : (k_ff + KW'(1));
         if (sts.a_last) begin
            i_in     = '0;
            j_in     = '0;
            sched_in = 1'b1;
         end
      end
      if (cmd.gen_rdj) begin
         i_in    = i_next;
         j_in    = j_new;
         hold_in = sb_rdata;
      end
      if (cmd.gen_wri) begin
         t_in = hold_ff + sb_rdata;
      end
      if (cmd.gen_wrj) begin
         // The read at t_ff collides with this write when t equals j.
         byp_in = (t_ff == j_ff);
      end
      if (cmd.gen_fin) begin
         rsp_in.keystream_byte = byp_ff ? hold_ff : sb_rdata;
         rsp_in.not_scheduled  = 1'b0;
      end
      if (cmd.flag_rsp) begin
         rsp_in.keystream_byte = '0;
         rsp_in.not_scheduled  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff  <= rc4_pkg::KEY_LENGTH_RESET;
         sched_ff <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         klen_ff  <= klen_in;
         sched_ff <= sched_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         valid_ff <= valid_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      k_ff    <= k_in;
      hold_ff <= hold_in;
      t_ff    <= t_in;
      byp_ff  <= byp_in;
      rsp_ff  <= rsp_in;
   end

   rc4_ram #(
      .WIDTH (BW),
      .DEPTH (rc4_pkg::SBOX_DEPTH)
   ) u_sbox (
      .clock (clock),
      .we    (sb_we),
      .waddr (sb_waddr),
      .wdata (sb_wdata),
      .raddr (sb_raddr),
      .rdata (sb_rdata)
   );

   rc4_ram #(
      .WIDTH (BW),
      .DEPTH (MAX_KEY_BYTES)
   ) u_key_store (
      .clock (clock),
      .we    (key_we),
      .waddr (KW'(req.key_index)),
      .wdata (req.key_byte),
      .raddr (k_ff),
      .rdata (key_rdata)
   );

   assign sts.a_last    = (a_ff == {SW{1'b1}});
   assign sts.scheduled = sched_ff;
   assign rsp_strobe    = valid_ff;
   assign rsp_word      = rsp_ff;

endmodule

### src/rc4_keystream_generator.sv
// Load word: taken while idle without leaving it, no result; the next word may follow at once.
// Schedule word: busy filling the permutation, then two reads and two writes per byte.
// Next word: G_RDI, G_RDJ, G_WRI, G_WRJ, G_FIN while busy, result registered after G_FIN;
// a next word before any schedule gives its flagged result in the following cycle.
// The permutation takes one read and one write per cycle; the receiver cannot stall.
// Synchronous active-high reset clears indices, key length (to 13) and the scheduled flag.
module rc4_keystream_generator #(
   parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  rc4_pkg::req_type                     req_word,
   output logic                                 rsp_strobe,
   output rc4_pkg::rsp_type                     rsp_word,
   input  logic                                 csr_we,
   input  logic [rc4_pkg::KEY_LENGTH_WIDTH-1:0] csr_wdata
);

   // The controller sequences every word through a fixed set of states; the
   // datapath holds the permutation, the key store, the indices and the
   // output register, and acts only on the commands it is given.
   rc4_pkg::cmd_type cmd;
   rc4_pkg::sts_type sts;

   rc4_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_word.action),
      .sts    (sts),
      .busy   (busy),
      .cmd    (cmd)
   );

   // The request word is sampled only in the cycle in which it is accepted,
   // so the datapath may look at it directly.
   rc4_datapath #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req_word),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .sts        (sts)
   );

   // A result only ever appears while the controller is idle.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> !busy)
      else $error("result strobed while busy");

   // A next word before any schedule answers at once with the flag and a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.action == rc4_pkg::ACT_NEXT) && !sts.scheduled)
      |=> (rsp_strobe && rsp_word.not_scheduled && (rsp_word.keystream_byte == '0)))
      else $error("unscheduled next word not flagged");

   // A schedule word always occupies the block.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.action == rc4_pkg::ACT_SCHEDULE)) |=> busy)
      else $error("schedule word did not start the key schedule");

   // An unflagged keystream byte only comes from a scheduled permutation.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.not_scheduled) |-> sts.scheduled)
      else $error("keystream byte without a schedule");

endmodule

### tb/sv/rc4_keystream_generator_tb.sv
module rc4_keystream_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_SLOTS = rc4_pkg::MAX_KEY_BYTES_DEFAULT;
   localparam int KLW       = rc4_pkg::KEY_LENGTH_WIDTH;

   // The one action code that the block must ignore completely.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // A key schedule keeps the block busy and gives no result, so we let it run on for
   // SETTLE_CYCLES, longer than a schedule, before touching the key length register.
   localparam int SETTLE_CYCLES = 1400;

   localparam int PHASES        = 8;
   localparam int RANDOM_WORDS  = 1320;
   localparam int DIRECTED_ROWS = 26;

   logic             clock;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   rc4_pkg::req_type req_word  = '0;
   logic             rsp_strobe;
   rc4_pkg::rsp_type rsp_word;
   logic             csr_we    = 1'b0;
   logic [KLW-1:0]   csr_wdata = '0;

   rc4_keystream_generator #(
      .MAX_KEY_BYTES(KEY_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Our own copy of the cipher state: the permutation, the key store, both
   // indices, whether a schedule has run yet, and the key length register.
   logic [7:0]     perm [rc4_pkg::SBOX_DEPTH];
   logic [7:0]     key_bytes [KEY_SLOTS];
   logic [7:0]     ptr_i      = 8'd0;
   logic [7:0]     ptr_j      = 8'd0;
   logic           perm_ready = 1'b0;
   logic [KLW-1:0] key_len    = rc4_pkg::KEY_LENGTH_RESET;

   // Keystream words that the block still owes us, oldest first.
   rc4_pkg::rsp_type keystream_due [$];

   int errors     = 0;
   int n_results  = 0;
   int n_flagged  = 0;
   int n_loads    = 0;
   int n_scheds   = 0;
   int n_ignored  = 0;
   int n_cfg      = 0;
   int calm_left  = 0;

   // One row of the directed part. Where fixed is set, the expected word is the
   // one typed into the row rather than the one the predictor works out.
   typedef struct packed {
      rc4_pkg::req_type word;
      logic             fixed;
      rc4_pkg::rsp_type fixed_rsp;
   } stim_row_type;

   // The directed part opens with next words before any schedule, which must come
   // back flagged and zero, and an unused action code. It then fills every slot
   // of the key store (so no schedule ever reads an unloaded byte), with bytes at
   // both extremes, schedules, and checks that a load after the schedule and a
   // further unused code leave the running keystream alone.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{rc4_pkg::ACT_NEXT,     4'hF, 8'hFF}, 1'b1, '{8'h00, 1'b1}},
      '{'{ACT_UNUSED,            4'hF, 8'hFF}, 1'b0, '0},
      '{'{rc4_pkg::ACT_NEXT,     4'h0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
      '{'{rc4_pkg::ACT_LOAD,     4'h0, 8'h00}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'h1, 8'hFF}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'h2, 8'h01}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'h3, 8'h80}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'h4, 8'h7F}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'h5, 8'hFE}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'h6, 8'h55}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'h7, 8'hAA}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'h8, 8'h10}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'h9, 8'h20}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'hA, 8'h40}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'hB, 8'h08}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'hC, 8'h04}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'hD, 8'h02}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'hE, 8'hC3}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'hF, 8'h3C}, 1'b0, '0},
      '{'{rc4_pkg::ACT_SCHEDULE, 4'hA, 8'h5A}, 1'b0, '0},
      '{'{rc4_pkg::ACT_NEXT,     4'h5, 8'hA5}, 1'b0, '0},
      '{'{rc4_pkg::ACT_NEXT,     4'hF, 8'hFF}, 1'b0, '0},
      '{'{rc4_pkg::ACT_NEXT,     4'h0, 8'h00}, 1'b0, '0},
      '{'{rc4_pkg::ACT_LOAD,     4'h0, 8'h99}, 1'b0, '0},
      '{'{ACT_UNUSED,            4'h3, 8'h77}, 1'b0, '0},
      '{'{rc4_pkg::ACT_NEXT,     4'h9, 8'h66}, 1'b0, '0}
   };

   // Key length for each random phase: zero (treated as one), the top of the
   // field (saturates to the store size), one, the store size, just above it,
   // the reset value and a short key. The last phase draws its own.
   logic [KLW-1:0] phase_key_len [PHASES] = '{
      5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd13, 5'd2, 5'd7
   };

   // Applies one accepted word to the cipher state and reports whether it gives
   // a keystream word, and which.
   function automatic logic rc4_apply(input rc4_pkg::req_type w,
                                      output rc4_pkg::rsp_type r);
      int unsigned span;
      int unsigned k;
      logic [7:0]  b;
      logic [7:0]  t;
      logic        produced;

      r        = '0;
      produced = 1'b0;
      case (w.action)
         rc4_pkg::ACT_LOAD: begin
            if (int'(w.key_index) < KEY_SLOTS)
               key_bytes[w.key_index] = w.key_byte;
            n_loads++;
         end
         rc4_pkg::ACT_SCHEDULE: begin
            // A zero length uses one byte; anything past the store size is clipped.
            span = (key_len == 0) ? 1 : (int'(key_len) > KEY_SLOTS) ? KEY_SLOTS : key_len;
            for (int a = 0; a < rc4_pkg::SBOX_DEPTH; a++)
               perm[a] = 8'(a);
            b = 8'd0;
            k = 0;
            for (int a = 0; a < rc4_pkg::SBOX_DEPTH; a++) begin
               b       = b + perm[a] + key_bytes[k];
               t       = perm[a];
               perm[a] = perm[b];
               perm[b] = t;
               k       = (k + 1 >= span) ? 0 : k + 1;
            end
            ptr_i      = 8'd0;
            ptr_j      = 8'd0;
            perm_ready = 1'b1;
            n_scheds++;
         end
         rc4_pkg::ACT_NEXT: begin
            produced = 1'b1;
            if (!perm_ready) begin
               // Nothing to generate from yet: a flagged zero, and no state moves.
               r.keystream_byte = 8'h00;
               r.not_scheduled  = 1'b1;
               n_flagged++;
            end else begin
               ptr_i       = ptr_i + 8'd1;
               ptr_j       = ptr_j + perm[ptr_i];
               t           = perm[ptr_i];
               perm[ptr_i] = perm[ptr_j];
               perm[ptr_j] = t;
               t           = perm[ptr_i] + perm[ptr_j];
               r.keystream_byte = perm[t];
               r.not_scheduled  = 1'b0;
            end
         end
         default: begin
            n_ignored++;
         end
      endcase
      return produced;
   endfunction

   // Random words lean heavily on next, since that is where the cipher does its
   // work; loads keep altering the key for later schedules, and schedules are
   // kept rare because each one fills and reshuffles the whole permutation.
   function automatic rc4_pkg::req_type random_word();
      rc4_pkg::req_type w;
      int               pick;

      w.key_index = 4'($urandom_range(0, 15));
      w.key_byte  = 8'($urandom_range(0, 255));
      pick        = $urandom_range(0, 99);
      if (pick < 70)
         w.action = rc4_pkg::ACT_NEXT;
      else if (pick < 92)
         w.action = rc4_pkg::ACT_LOAD;
      else if (pick < 95)
         w.action = rc4_pkg::ACT_SCHEDULE;
      else
         w.action = ACT_UNUSED;
      return w;
   endfunction

   // Offers one word after a random gap and waits until the block takes it. The
   // sender now and then runs a calm stretch with no gaps at all. When there is
   // no gap, start is simply left high from the previous word.
   task automatic send_word(input rc4_pkg::req_type w, input logic fixed,
                            input rc4_pkg::rsp_type fixed_rsp);
      int               gap;
      rc4_pkg::rsp_type r;

      if (calm_left > 0) begin
         gap = 0;
         calm_left--;
      end else begin
         gap = $urandom_range(0, 6);
         if ($urandom_range(0, 49) == 0)
            calm_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      if (rc4_apply(w, r))
         keystream_due.push_back(fixed ? fixed_rsp : r);
   endtask

   // Waits until every owed word has arrived, then lets a schedule run out.
   task automatic settle();
      start <= 1'b0;
      while (keystream_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key_length(input logic [KLW-1:0] v);
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      key_len = v;
      n_cfg++;
   endtask

   // Result checker: every strobed word is matched against the oldest one owed.
   always @(posedge clock) begin
      rc4_pkg::rsp_type due;
      if (!reset && rsp_strobe) begin
         n_results++;
         if (keystream_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual byte %02h flag %0b",
                     $time, rsp_word.keystream_byte, rsp_word.not_scheduled);
         end else begin
            due = keystream_due.pop_front();
            if (rsp_word.keystream_byte !== due.keystream_byte) begin
               errors++;
               $display("%0t: keystream_byte mismatch, expected %02h, actual %02h",
                        $time, due.keystream_byte, rsp_word.keystream_byte);
            end
            if (rsp_word.not_scheduled !== due.not_scheduled) begin
               errors++;
               $display("%0t: not_scheduled mismatch, expected %0b, actual %0b",
                        $time, due.not_scheduled, rsp_word.not_scheduled);
            end
         end
      end
   end

   initial begin
      rc4_pkg::req_type w;
      int               counted;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < DIRECTED_ROWS; n++)
         send_word(directed_rows[n].word, directed_rows[n].fixed, directed_rows[n].fixed_rsp);

      // Each phase changes the key length while the block is idle, then opens
      // with a schedule so that the new length takes effect straight away.
      for (int p = 0; p < PHASES; p++) begin
         settle();
         if (p == PHASES - 1)
            write_key_length(KLW'($urandom_range(0, 31)));
         else
            write_key_length(phase_key_len[p]);
         w.action    = rc4_pkg::ACT_SCHEDULE;
         w.key_index = 4'($urandom_range(0, 15));
         w.key_byte  = 8'($urandom_range(0, 255));
         send_word(w, 1'b0, '0);
         counted = 1;
         while (counted < RANDOM_WORDS / PHASES) begin
            w = random_word();
            send_word(w, 1'b0, '0);
            if (w.action != ACT_UNUSED)
               counted++;
         end
      end

      settle();
      if (keystream_due.size() != 0) begin
         errors += keystream_due.size();
         $display("%0t: %0d keystream words expected but never delivered",
                  $time, keystream_due.size());
      end

      $display("Checked %0d keystream words (%0d flagged) across %0d key schedules,",
               n_results, n_flagged, n_scheds);
      $display("with %0d key loads, %0d ignored words and %0d key length writes.",
               n_loads, n_ignored, n_cfg);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Backstop in case the block stops answering: generous even if every word
   // were a key schedule.
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
